@@ rtl/core/rref_null_space_basis_core_assert.svh @@
// Assertion macros used by the checker file of the null space core.
// Each use expands to one labelled concurrent assertion that reports by $error.
`ifndef RREF_NULL_SPACE_BASIS_CORE_ASSERT_SVH
`define RREF_NULL_SPACE_BASIS_CORE_ASSERT_SVH

// Same-cycle implication.
`define RNS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RNS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/rns_pkg.sv @@
// ----------------------------------------------------------------------------
// rns_pkg
// Types, sizes and helpers shared by the null space core and its parts.
// ----------------------------------------------------------------------------
package rns_pkg;

	localparam int MAX_DIM    = 8;
	localparam int DATA_WIDTH = 32;
	localparam int DEPTH      = MAX_DIM * MAX_DIM;
	localparam int IDX_W      = $clog2(MAX_DIM);
	localparam int CNT_W      = $clog2(MAX_DIM + 1);
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int POS_W      = $clog2(DEPTH + 1);
	localparam int CFG_DATA_W = 4;

	localparam logic signed [DATA_WIDTH-1:0] Q_ONE = DATA_WIDTH'(65536);

	typedef enum logic [1:0] {
		CFG_ROW_COUNT,
		CFG_COL_COUNT,
		CFG_PIVOT_IN_ROWS,
		CFG_VECTORS_AS_ROWS
	} cfg_idx_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] element;
		logic                         last_element;
	} elem_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] value;
		logic [IDX_W-1:0]             out_row;
		logic [IDX_W-1:0]             out_col;
		logic                         last_of_run;
		logic                         trivial;
	} result_t;

	// one write and one read port of the matrix store
	typedef struct packed {
		logic                  we;
		logic [ADDR_W-1:0]     waddr;
		logic [DATA_WIDTH-1:0] wdata;
		logic                  re;
		logic [ADDR_W-1:0]     raddr;
	} store_req_t;

	// zero counts as one, anything above the maximum as the maximum
	function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (32'(v) > MAX_DIM) begin
			r = CNT_W'(MAX_DIM);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

	// row-major address r*cols + c
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [CNT_W-1:0] cols);
		logic [ADDR_W+1:0] prod;
		prod = (ADDR_W+2)'(r) * (ADDR_W+2)'(cols) + (ADDR_W+2)'(c);
		return prod[ADDR_W-1:0];
	endfunction

	// number of set flags below position j
	function automatic logic [IDX_W-1:0] rank_below(input logic [MAX_DIM-1:0] flags,
			input logic [IDX_W-1:0] j);
		logic [IDX_W-1:0] n;
		n = '0;
		for (int b = 0; b < MAX_DIM; b++) begin
			if (b < 32'(j) && flags[b]) begin
				n = n + IDX_W'(1);
			end
		end
		return n;
	endfunction

	// negation, most negative code saturates to the largest
	function automatic logic signed [DATA_WIDTH-1:0] neg_sat(
			input logic signed [DATA_WIDTH-1:0] v);
		logic signed [DATA_WIDTH-1:0] r;
		if (v == {1'b1, {(DATA_WIDTH-1){1'b0}}}) begin
			r = {1'b0, {(DATA_WIDTH-1){1'b1}}};
		end else begin
			r = -v;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/rns_store.sv @@
// ----------------------------------------------------------------------------
// rns_store
// Matrix store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rns_store import rns_pkg::*; (
	input  logic                         clk,
	input  store_req_t                   req,
	output logic signed [DATA_WIDTH-1:0] rdata
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = $signed(rdata_q);

endmodule

@@ rtl/core/rref_null_space_basis_core.sv @@
// ----------------------------------------------------------------------------
// rref_null_space_basis_core
// Null space basis of a reduced echelon matrix of up to 8 by 8 Q16.16 entries.
//
// The matrix comes in as words in row-major order, one word per cycle, the
// last one flagged by last_element. After that word the core stalls the input
// and works through a single read port of the matrix store: a pivot scan of
// all rows*cols cells, a sweep over the n variables that lists the free ones,
// then the basis entries at one word per cycle while the sink keeps up (every
// entry goes through the same store read; only pivot entries take the
// saturating negate). The input opens again once the final entry has left the
// read stage. Column mode takes a column as pivot when it holds the first one
// of a row; row mode is the transposed case. A matrix with no free variable
// gives one trivial word. Store entries never loaded since reset read as
// anything. Register writes are taken at any time but belong in idle gaps.
// ----------------------------------------------------------------------------
module rref_null_space_basis_core import rns_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  elem_valid,
	output logic                  elem_stall,
	input  elem_t                 elem,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_SCAN_END,
		ST_BUILD,
		ST_EMIT,
		ST_DRAIN
	} state_t;

	typedef enum logic [1:0] {
		KIND_ZERO,
		KIND_ONE,
		KIND_PIVOT
	} kind_t;

	state_t state_q;

	// configuration
	logic [CFG_DATA_W-1:0] row_count_q;
	logic [CFG_DATA_W-1:0] col_count_q;
	logic                  pivot_in_rows_q;
	logic                  vectors_as_rows_q;

	// load and pivot state
	logic [POS_W-1:0]   load_pos_q;
	logic [MAX_DIM-1:0] pivot_flags_q;
	logic [MAX_DIM-1:0] seen_q;

	// sequencer counters
	logic [IDX_W-1:0] o_q, i_q;        // scan: line, position along the line
	logic [IDX_W-1:0] build_j_q;
	logic [CNT_W-1:0] nf_q;
	logic [IDX_W-1:0] free_q [MAX_DIM];
	logic [IDX_W-1:0] a_q, b_q;        // emission: output row, output column

	// read stage
	logic             scan_v_s1;
	logic [IDX_W-1:0] scan_line_s1;
	logic [IDX_W-1:0] scan_tgt_s1;
	logic             emit_v_s1;
	kind_t            kind_s1;
	logic [IDX_W-1:0] row_s1, col_s1;
	logic             last_s1, triv_s1;

	// output register
	logic    res_v_q;
	result_t res_q;

	// combinational
	logic [CNT_W-1:0]             rows_c, cols_c, n_c;
	logic [CNT_W-1:0]             scan_outer_c, scan_inner_c;
	logic [CNT_W-1:0]             emit_outer_c, emit_inner_c;
	logic                         scan_o_end, scan_i_end;
	logic                         emit_a_end, emit_b_end;
	logic [IDX_W-1:0]             emit_k, emit_j, emit_f, emit_rank;
	kind_t                        emit_kind;
	logic [ADDR_W-1:0]            scan_addr, emit_addr;
	store_req_t                   store_req;
	logic signed [DATA_WIDTH-1:0] rd_data;
	logic                         elem_accept, s1_move, emit_issue;
	logic signed [DATA_WIDTH-1:0] value_c;

	assign rows_c = clamp_dim(row_count_q);
	assign cols_c = clamp_dim(col_count_q);
	assign n_c    = pivot_in_rows_q ? rows_c : cols_c;

	// scan walks along each line of the chosen kind; hits mark the crossing line
	assign scan_outer_c = pivot_in_rows_q ? cols_c : rows_c;
	assign scan_inner_c = pivot_in_rows_q ? rows_c : cols_c;
	assign scan_o_end   = CNT_W'(o_q) == scan_outer_c - CNT_W'(1);
	assign scan_i_end   = CNT_W'(i_q) == scan_inner_c - CNT_W'(1);
	assign scan_addr    = pivot_in_rows_q ? cell_addr(i_q, o_q, cols_c)
	                                      : cell_addr(o_q, i_q, cols_c);

	// emission index mapping
	assign emit_outer_c = vectors_as_rows_q ? nf_q : n_c;
	assign emit_inner_c = vectors_as_rows_q ? n_c : nf_q;
	assign emit_a_end   = CNT_W'(a_q) == emit_outer_c - CNT_W'(1);
	assign emit_b_end   = CNT_W'(b_q) == emit_inner_c - CNT_W'(1);
	assign emit_k       = vectors_as_rows_q ? a_q : b_q;
	assign emit_j       = vectors_as_rows_q ? b_q : a_q;
	assign emit_f       = free_q[emit_k];
	assign emit_rank    = rank_below(pivot_flags_q, emit_j);
	assign emit_addr    = pivot_in_rows_q ? cell_addr(emit_f, emit_rank, cols_c)
	                                      : cell_addr(emit_rank, emit_f, cols_c);

	always_comb begin
		if (emit_j == emit_f) begin
			emit_kind = KIND_ONE;
		end else if (pivot_flags_q[emit_j]) begin
			emit_kind = KIND_PIVOT;
		end else begin
			emit_kind = KIND_ZERO;
		end
	end

	// handshakes
	assign elem_stall   = state_q != ST_LOAD;
	assign elem_accept  = elem_valid && !elem_stall;
	assign s1_move      = emit_v_s1 && (!res_v_q || !result_stall);
	assign emit_issue   = (state_q == ST_EMIT) && (!emit_v_s1 || s1_move);
	assign result_valid = res_v_q;
	assign result       = res_q;

	// store port
	always_comb begin
		store_req.we    = elem_accept && (32'(load_pos_q) < DEPTH);
		store_req.waddr = load_pos_q[ADDR_W-1:0];
		store_req.wdata = elem.element;
		store_req.re    = (state_q == ST_SCAN) || emit_issue;
		store_req.raddr = (state_q == ST_SCAN) ? scan_addr : emit_addr;
	end

	rns_store u_store (
		.clk   (clk),
		.req   (store_req),
		.rdata (rd_data)
	);

	always_comb begin
		case (kind_s1)
			KIND_ONE:   value_c = Q_ONE;
			KIND_PIVOT: value_c = neg_sat(rd_data);
			default:    value_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_LOAD;
			row_count_q       <= CFG_DATA_W'(MAX_DIM);
			col_count_q       <= CFG_DATA_W'(MAX_DIM);
			pivot_in_rows_q   <= 1'b0;
			vectors_as_rows_q <= 1'b0;
			load_pos_q        <= '0;
			pivot_flags_q     <= '0;
			seen_q            <= '0;
			o_q               <= '0;
			i_q               <= '0;
			build_j_q         <= '0;
			nf_q              <= '0;
			for (int e = 0; e < MAX_DIM; e++) begin
				free_q[e] <= '0;
			end
			a_q               <= '0;
			b_q               <= '0;
			scan_v_s1         <= 1'b0;
			scan_line_s1      <= '0;
			scan_tgt_s1       <= '0;
			emit_v_s1         <= 1'b0;
			kind_s1           <= KIND_ZERO;
			row_s1            <= '0;
			col_s1            <= '0;
			last_s1           <= 1'b0;
			triv_s1           <= 1'b0;
			res_v_q           <= 1'b0;
			res_q             <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROW_COUNT:       row_count_q       <= cfg_data;
					CFG_COL_COUNT:       col_count_q       <= cfg_data;
					CFG_PIVOT_IN_ROWS:   pivot_in_rows_q   <= cfg_data[0];
					CFG_VECTORS_AS_ROWS: vectors_as_rows_q <= cfg_data[0];
					default: ;
				endcase
			end

			// scan hits: first one along a line claims the crossing line
			scan_v_s1 <= (state_q == ST_SCAN);
			if (scan_v_s1 && !seen_q[scan_line_s1] && rd_data == Q_ONE) begin
				seen_q[scan_line_s1]       <= 1'b1;
				pivot_flags_q[scan_tgt_s1] <= 1'b1;
			end

			// read stage into output register
			if (s1_move) begin
				res_v_q           <= 1'b1;
				res_q.value       <= value_c;
				res_q.out_row     <= row_s1;
				res_q.out_col     <= col_s1;
				res_q.last_of_run <= last_s1;
				res_q.trivial     <= triv_s1;
			end else if (res_v_q && !result_stall) begin
				res_v_q <= 1'b0;
			end
			if (s1_move && !emit_issue) begin
				emit_v_s1 <= 1'b0;
			end

			unique case (state_q)
				ST_LOAD: begin
					if (elem_accept) begin
						if (elem.last_element) begin
							load_pos_q    <= '0;
							pivot_flags_q <= '0;
							seen_q        <= '0;
							o_q           <= '0;
							i_q           <= '0;
							state_q       <= ST_SCAN;
						end else if (32'(load_pos_q) < DEPTH) begin
							load_pos_q <= load_pos_q + POS_W'(1);
						end
					end
				end
				ST_SCAN: begin
					scan_line_s1 <= o_q;
					scan_tgt_s1  <= i_q;
					if (scan_i_end) begin
						i_q <= '0;
						o_q <= o_q + IDX_W'(1);
						if (scan_o_end) begin
							state_q <= ST_SCAN_END;
						end
					end else begin
						i_q <= i_q + IDX_W'(1);
					end
				end
				ST_SCAN_END: begin
					build_j_q <= '0;
					nf_q      <= '0;
					state_q   <= ST_BUILD;
				end
				ST_BUILD: begin
					if (!pivot_flags_q[build_j_q]) begin
						free_q[nf_q[IDX_W-1:0]] <= build_j_q;
						nf_q                    <= nf_q + CNT_W'(1);
					end
					build_j_q <= build_j_q + IDX_W'(1);
					if (CNT_W'(build_j_q) == n_c - CNT_W'(1)) begin
						a_q     <= '0;
						b_q     <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_issue) begin
						emit_v_s1 <= 1'b1;
						if (nf_q == '0) begin
							// no free variable: one trivial word
							kind_s1 <= KIND_ZERO;
							row_s1  <= '0;
							col_s1  <= '0;
							last_s1 <= 1'b1;
							triv_s1 <= 1'b1;
							state_q <= ST_DRAIN;
						end else begin
							row_s1  <= a_q;
							col_s1  <= b_q;
							kind_s1 <= emit_kind;
							last_s1 <= emit_a_end && emit_b_end;
							triv_s1 <= 1'b0;
							if (emit_b_end) begin
								b_q <= '0;
								a_q <= a_q + IDX_W'(1);
								if (emit_a_end) begin
									state_q <= ST_DRAIN;
								end
							end else begin
								b_q <= b_q + IDX_W'(1);
							end
						end
					end
				end
				ST_DRAIN: begin
					// read stage must be empty before the store is scanned again
					if (!emit_v_s1 || s1_move) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/rns_checker.sv @@
// ----------------------------------------------------------------------------
// rns_checker
// Port-level checks of the null space core, bound to the top level.
// ----------------------------------------------------------------------------
`include "rref_null_space_basis_core_assert.svh"

module rns_checker import rns_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  elem_valid,
	input logic                  elem_stall,
	input elem_t                 elem,
	input logic                  result_valid,
	input logic                  result_stall,
	input result_t               result
);

	// a stalled result word holds
	`RNS_ASSERT_NXT(a_res_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result word changed")

	// the closing word of a matrix stops the input
	`RNS_ASSERT_NXT(a_busy_after_last, clk, arst_n, elem_valid && !elem_stall && elem.last_element, elem_stall, "input open right after last element")

	// a trivial word is a lone zero at the origin
	`RNS_ASSERT_IMP(a_trivial_shape, clk, arst_n, result_valid && result.trivial, result.last_of_run && result.value == '0 && result.out_row == '0 && result.out_col == '0, "malformed trivial word")

	// no new matrix is taken while a run is unfinished
	`RNS_ASSERT_IMP(a_no_load_mid_run, clk, arst_n, result_valid && !result.last_of_run, elem_stall, "input open during emission")

endmodule

bind rref_null_space_basis_core rns_checker u_rns_checker (.*);
